/* hdl/ihre_pkg.sv */
// Shared types, sizes and helper functions for the Intel HEX record encoder.
// Used by every module of the block; no dependencies of its own.
package ihre_pkg;

   // Bytes per data record line
   localparam int LINE_BYTES = 16;
   localparam int FILL_W     = $clog2(LINE_BYTES + 1);
   localparam int STORE_AW   = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
   // Byte position inside a record: count, addr hi, addr lo, type, data, checksum
   localparam int PTR_W      = $clog2(LINE_BYTES + 6);
   localparam int HDR_BYTES  = 4;

   localparam logic [7:0] TYPE_DATA = 8'h00;
   localparam logic [7:0] TYPE_EOF  = 8'h01;
   localparam logic [7:0] TYPE_ELA  = 8'h04;
   localparam logic [7:0] ELA_COUNT = 8'h02;

   localparam logic [6:0] CHAR_COLON = 7'h3A;
   localparam logic [6:0] CHAR_LF    = 7'h0A;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       last_char;
   } rsp_type;

   // Input kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Record kinds
   typedef enum logic [1:0] {
      REC_DATA = 2'd0,
      REC_ELA  = 2'd1,
      REC_EOF  = 2'd2
   } rec_type;

   // Character slot selection for the formatter
   typedef enum logic [1:0] {
      SEL_COLON = 2'd0,
      SEL_HI    = 2'd1,
      SEL_LO    = 2'd2,
      SEL_LF    = 2'd3
   } chr_sel_type;

   typedef struct packed {
      logic        clear_sum;
      logic        add_sum;
      logic        use_chk;
      chr_sel_type sel;
   } fmt_ctl_type;

   // Map a nibble to an uppercase hex ASCII digit
   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] c;
      if (nib < 4'd10) begin
         c = 7'h30 + {3'b000, nib};
      end else begin
         c = 7'h37 + {3'b000, nib};
      end
      return c;
   endfunction

endpackage

/* hdl/intel_hex_record_encoder.sv */
// Top level of the Intel HEX record encoder: sequencer, formatter and the
// registered result stage. Depends on ihre_pkg, ihre_ctrl and ihre_fmt.
//
// Usage:
//   req channel: one transaction per raw byte (kind = 0) or end of stream
//   (kind = 1). req_stall is high while a record is being emitted.
//   rsp channel: one ASCII character per transaction; last_char marks the
//   final character caused by one request transaction.
//   A data byte that does not complete a 16-byte line is absorbed and
//   produces nothing. The byte completing a line starts a data record of
//   44 characters, one per cycle while rsp_stall allows (60 characters
//   when the address enters a new 64 KiB region and a type 04 record
//   follows). End of stream emits any partial line, then ":00000001FF" LF
//   (12 characters), and clears the fill count and address.
//   The character loop in the sequencer, one character per cycle through a
//   shared checksum adder while rsp_stall allows, sets the rate.
//   Reset clears the fill count, address and result valid flag; the line
//   store needs no clearing. When rsp_stall is high the result register
//   holds its character and the sequencer waits.
module intel_hex_record_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ihre_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ihre_pkg::rsp_type rsp_payload
);
   import ihre_pkg::*;

   logic        req_accept;
   logic        slot_free;
   logic        busy;
   logic        emit;
   logic        last;
   logic [7:0]  byte_val;
   logic [6:0]  char_val;
   fmt_ctl_type fmt_ctl;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   ihre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_payload),
      .advance    (slot_free),
      .busy       (busy),
      .emit       (emit),
      .last       (last),
      .byte_val   (byte_val),
      .fmt_ctl    (fmt_ctl)
   );

   ihre_fmt u_fmt (
      .clock    (clock),
      .step     (emit && slot_free),
      .ctl      (fmt_ctl),
      .byte_val (byte_val),
      .char_out (char_val)
   );

   // Load a new character when the slot frees, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && slot_free) begin
         rsp_data_ff.out_char  <= char_val;
         rsp_data_ff.last_char <= last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

/* hdl/ihre_fmt.sv */
// Character formatter: running checksum accumulator and hex digit generation.
// Depends on ihre_pkg for the control struct and hex_char.
module ihre_fmt (
   input  logic                clock,
   input  logic                step,
   input  ihre_pkg::fmt_ctl_type ctl,
   input  logic [7:0]          byte_val,
   output logic [6:0]          char_out
);
   import ihre_pkg::*;

   logic [7:0] sum_ff;
   logic [7:0] sum_in;
   logic [7:0] byte_eff;

   // Pick the record byte or the two's-complement checksum
   always_comb begin
      byte_eff = ctl.use_chk ? (8'd0 - sum_ff) : byte_val;
   end

   // Shared adder: accumulate one byte per emitted pair of digits
   always_comb begin
      sum_in = sum_ff;
      if (ctl.clear_sum) begin
         sum_in = 8'd0;
      end else if (ctl.add_sum) begin
         sum_in = sum_ff + byte_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         sum_ff <= sum_in;
      end
   end

   // Build the ASCII character for this slot
   always_comb begin
      case (ctl.sel)
         SEL_COLON: char_out = CHAR_COLON;
         SEL_HI:    char_out = hex_char(byte_eff[7:4]);
         SEL_LO:    char_out = hex_char(byte_eff[3:0]);
         SEL_LF:    char_out = CHAR_LF;
         default:   char_out = CHAR_LF;
      endcase
   end

endmodule

/* hdl/ihre_ctrl.sv */
// Record sequencer: line store, fill and address counters, and the
// per-character state machine. Depends on ihre_pkg.
module ihre_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_accept,
   input  ihre_pkg::req_type     req_data,
   input  logic                  advance,
   output logic                  busy,
   output logic                  emit,
   output logic                  last,
   output logic [7:0]            byte_val,
   output ihre_pkg::fmt_ctl_type fmt_ctl
);
   import ihre_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_COLON = 5'b00010,
      S_HI    = 5'b00100,
      S_LO    = 5'b01000,
      S_LF    = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   rec_type            rec_ff, rec_in;
   logic               flush_ff, flush_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [31:0]        addr_ff, addr_in;
   logic [7:0]         store_ff [LINE_BYTES];

   logic [PTR_W-1:0]   cnt_p;
   logic [PTR_W-1:0]   chk_pos;
   logic [PTR_W-1:0]   ptr_off;
   logic [7:0]         cnt_byte;
   logic [31:0]        addr_next;
   logic [FILL_W-1:0]  fill_inc;

   assign busy      = (state_ff != S_IDLE);
   assign emit      = busy;
   assign fill_inc  = fill_ff + FILL_W'(1);
   assign addr_next = addr_ff + 32'(LINE_BYTES);

   // Byte count of the record in flight
   always_comb begin
      case (rec_ff)
         REC_DATA: cnt_p = PTR_W'(fill_ff);
         REC_ELA:  cnt_p = PTR_W'(ELA_COUNT);
         default:  cnt_p = '0;
      endcase
      cnt_byte = 8'(cnt_p);
      chk_pos  = PTR_W'(HDR_BYTES) + cnt_p;
      ptr_off  = ptr_ff - PTR_W'(HDR_BYTES);
   end

   // Select the record byte at the current position
   always_comb begin
      if (ptr_ff == PTR_W'(0)) begin
         byte_val = cnt_byte;
      end else if (ptr_ff == PTR_W'(1)) begin
         byte_val = (rec_ff == REC_DATA) ? addr_ff[15:8] : 8'h00;
      end else if (ptr_ff == PTR_W'(2)) begin
         byte_val = (rec_ff == REC_DATA) ? addr_ff[7:0] : 8'h00;
      end else if (ptr_ff == PTR_W'(3)) begin
         case (rec_ff)
            REC_DATA: byte_val = TYPE_DATA;
            REC_ELA:  byte_val = TYPE_ELA;
            default:  byte_val = TYPE_EOF;
         endcase
      end else if (rec_ff == REC_DATA) begin
         byte_val = store_ff[ptr_off[STORE_AW-1:0]];
      end else begin
         byte_val = ptr_off[0] ? addr_ff[23:16] : addr_ff[31:24];
      end
   end

   // Sequencer: one character per advance
   always_comb begin
      state_in        = state_ff;
      ptr_in          = ptr_ff;
      rec_in          = rec_ff;
      flush_in        = flush_ff;
      fill_in         = fill_ff;
      addr_in         = addr_ff;
      last            = 1'b0;
      fmt_ctl.clear_sum = 1'b0;
      fmt_ctl.add_sum   = 1'b0;
      fmt_ctl.use_chk   = (ptr_ff == chk_pos);
      fmt_ctl.sel       = SEL_COLON;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               ptr_in = '0;
               if (req_data.kind == KIND_DATA) begin
                  fill_in = fill_inc;
                  if (fill_inc == FILL_W'(LINE_BYTES)) begin
                     rec_in   = REC_DATA;
                     flush_in = 1'b0;
                     state_in = S_COLON;
                  end
               end else begin
                  flush_in = 1'b1;
                  rec_in   = (fill_ff != '0) ? REC_DATA : REC_EOF;
                  state_in = S_COLON;
               end
            end
         end
         S_COLON: begin
            fmt_ctl.sel       = SEL_COLON;
            fmt_ctl.clear_sum = 1'b1;
            if (advance) begin
               state_in = S_HI;
            end
         end
         S_HI: begin
            fmt_ctl.sel = SEL_HI;
            if (advance) begin
               state_in = S_LO;
            end
         end
         S_LO: begin
            fmt_ctl.sel     = SEL_LO;
            fmt_ctl.add_sum = 1'b1;
            if (advance) begin
               if (ptr_ff == chk_pos) begin
                  state_in = S_LF;
               end else begin
                  ptr_in   = ptr_ff + PTR_W'(1);
                  state_in = S_HI;
               end
            end
         end
         S_LF: begin
            fmt_ctl.sel = SEL_LF;
            ptr_in      = '0;
            case (rec_ff)
               REC_DATA: begin
                  if (flush_ff) begin
                     if (advance) begin
                        rec_in   = REC_EOF;
                        fill_in  = '0;
                        state_in = S_COLON;
                     end
                  end else begin
                     if (addr_next[31:16] != addr_ff[31:16]) begin
                        if (advance) begin
                           rec_in   = REC_ELA;
                           fill_in  = '0;
                           addr_in  = addr_next;
                           state_in = S_COLON;
                        end
                     end else begin
                        last = 1'b1;
                        if (advance) begin
                           fill_in  = '0;
                           addr_in  = addr_next;
                           state_in = S_IDLE;
                        end
                     end
                  end
               end
               REC_ELA: begin
                  last = 1'b1;
                  if (advance) begin
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  last = 1'b1;
                  if (advance) begin
                     fill_in  = '0;
                     addr_in  = '0;
                     flush_in = 1'b0;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ptr_ff   <= '0;
         rec_ff   <= REC_DATA;
         flush_ff <= 1'b0;
         fill_ff  <= '0;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         rec_ff   <= rec_in;
         flush_ff <= flush_in;
         fill_ff  <= fill_in;
         addr_ff  <= addr_in;
      end
   end

   // Capture incoming data bytes into the line store
   always_ff @(posedge clock) begin
      if (req_accept && (req_data.kind == KIND_DATA)) begin
         store_ff[fill_ff[STORE_AW-1:0]] <= req_data.data_byte;
      end
   end

endmodule

/* hdl/ihre_checker.sv */
// Port-level checker for the Intel HEX record encoder and its bind.
// Depends on ihre_pkg and the top level intel_hex_record_encoder.
module ihre_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ihre_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ihre_pkg::rsp_type rsp_payload
);
   import ihre_pkg::*;

   // A stalled result holds its character
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp changed while stalled");

   // End of stream always produces output, so the block goes busy
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.kind == KIND_END) |=> req_stall)
      else $error("end of stream did not start a record");

   // Every transaction closes with a line feed
   a_last_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_char |-> rsp_payload.out_char == CHAR_LF)
      else $error("last character is not LF");

   // No result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind intel_hex_record_encoder ihre_checker u_ihre_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
